>>> rtl/rank_select_delete_set_top_defines.svh
// shared assertion macros
`ifndef RANK_SELECT_DELETE_SET_TOP_DEFINES_SVH
`define RANK_SELECT_DELETE_SET_TOP_DEFINES_SVH

// same-cycle property, off during reset
`define RSDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// next-cycle consequence, off during reset
`define RSDS_ASSERT_NEXT(name, cond, conseq, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

>>> rtl/rsds_pkg.sv
`default_nettype none

package rsds_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned LEVELS   = $clog2(CAPACITY);
  localparam int unsigned KEY_W    = LEVELS;
  localparam int unsigned CNT_W    = LEVELS + 1;
  localparam int unsigned RANK_W   = 11;

  // descent token handed from one tree level to the next
  typedef struct packed {
    logic              go;
    logic [LEVELS-1:0] idx;
    logic [LEVELS-1:0] rank;
  } walk_t;

  // refill sweep control, shared by all levels
  typedef struct packed {
    logic              en;
    logic [LEVELS-2:0] addr;
    logic [CNT_W-1:0]  fill_n;
  } sweep_t;

  // keys below fill_n present: count of a node covering [base, base+span)
  function automatic logic [CNT_W-1:0] fill_count(input logic [CNT_W-1:0] n,
                                                  input logic [CNT_W-1:0] base,
                                                  input logic [CNT_W-1:0] span);
    logic [CNT_W-1:0] diff;
    diff = n - base;
    if (n <= base) begin
      return '0;
    end else if (diff > span) begin
      return span;
    end else begin
      return diff;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/rsds_cell.sv
`default_nettype none
`include "rank_select_delete_set_top_defines.svh"

module rsds_cell
  import rsds_pkg::*;
#(
  parameter int unsigned LEVEL = 1
) (
  input  logic   clk,
  input  logic   rst,
  input  sweep_t sweep,
  input  walk_t  wk_in,
  output walk_t  wk_out
);

  localparam int unsigned CW    = LEVELS - LEVEL + 1;
  localparam int unsigned NODES = 1 << (LEVEL - 1);
  localparam int unsigned AW    = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam int unsigned SHIFT = LEVELS - LEVEL;
  localparam int unsigned SPAN  = 1 << SHIFT;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] right;
  } pair_t;

  pair_t             mem [NODES];
  pair_t             rd_pair;
  pair_t             wr_pair;
  pair_t             fill_pair;
  logic              go_q;
  logic [AW-1:0]     addr_q;
  logic [LEVELS-1:0] idx_q;
  logic [LEVELS-1:0] rank_q;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     sw_addr;
  logic [CNT_W-1:0]  base_l;
  logic [CNT_W-1:0]  base_r;
  logic [LEVELS-1:0] left_ext;
  logic              take_right;

  assign rd_addr = wk_in.idx[AW-1:0] & AW'(NODES - 1);
  assign sw_addr = sweep.addr[AW-1:0] & AW'(NODES - 1);

  // refill values for the two children at the sweep address
  assign base_l = CNT_W'({sw_addr, 1'b0}) << SHIFT;
  assign base_r = CNT_W'({sw_addr, 1'b1}) << SHIFT;
  assign fill_pair.left  = CW'(fill_count(sweep.fill_n, base_l, CNT_W'(SPAN)));
  assign fill_pair.right = CW'(fill_count(sweep.fill_n, base_r, CNT_W'(SPAN)));

  // pick a child and take one off its count
  assign left_ext   = LEVELS'(rd_pair.left);
  assign take_right = (rank_q >= left_ext);

  always_comb begin
    wr_pair = rd_pair;
    if (take_right) begin
      wr_pair.right = rd_pair.right - CW'(1);
    end else begin
      wr_pair.left = rd_pair.left - CW'(1);
    end
  end

  assign wk_out.go   = go_q;
  assign wk_out.idx  = (idx_q << 1) | LEVELS'(take_right);
  assign wk_out.rank = take_right ? (rank_q - left_ext) : rank_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      go_q <= 1'b0;
    end else begin
      go_q <= wk_in.go;
    end
  end

  always_ff @(posedge clk) begin
    addr_q  <= rd_addr;
    idx_q   <= wk_in.idx;
    rank_q  <= wk_in.rank;
    rd_pair <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sweep.en) begin
      mem[sw_addr] <= fill_pair;
    end else if (go_q) begin
      mem[addr_q] <= wr_pair;
    end
  end

  `RSDS_ASSERT(a_chosen_nonempty,
    go_q |-> ((take_right && (rd_pair.right != '0)) || (!take_right && (rd_pair.left != '0))),
    "descent entered an empty subtree")
  `RSDS_ASSERT(a_no_walk_in_sweep, sweep.en |-> !go_q, "descent during refill sweep")
  `RSDS_ASSERT_NEXT(a_single_token, go_q, !go_q, "two items in one level back to back")

endmodule

`default_nettype wire

>>> rtl/rank_select_delete_set_top.sv
`default_nettype none
`include "rank_select_delete_set_top_defines.svh"

// Ordered set over keys 0..1023 with delete-by-rank. Writing cfg_wr_data
// (set_size, values above 1024 load 1024) reloads keys 0..set_size-1; each
// item on s_axis names a rank (negative counts from the largest) and yields
// one result with the removed key, a removed flag and the remaining count.
// The count tree is a chain of ten level cells, each with its own memory of
// child-count pairs; an in-range item walks down one cell per cycle, its
// result is registered after the last cell and the next item is taken only
// after its walk ends. An out-of-range item skips the tree and its result is
// registered directly. After reset and after every set_size write a refill
// sweep rewrites all level memories in parallel, with s_axis_tready low.
// One result can wait on m_axis while the next item is processed.
module rank_select_delete_set_top
  import rsds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_rank[10:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // deleted_key[9:0], remaining[20:10]
  output logic        m_axis_tuser    // deleted
);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WALK  = 3'b100
  } state_t;

  state_t            state;
  logic [LEVELS-2:0] sweep_cnt;
  logic [CNT_W-1:0]  fill_n;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  cfg_n;

  logic              out_valid;
  logic [KEY_W-1:0]  out_key;
  logic              out_del;
  logic [CNT_W-1:0]  out_rem;
  logic              pend_valid;
  logic [KEY_W-1:0]  pend_key;
  logic              pend_del;
  logic [CNT_W-1:0]  pend_rem;

  logic              acc;
  logic [RANK_W-1:0] rank_raw;
  logic [RANK_W:0]   adj;
  logic              in_range;
  logic              walk_end;
  logic              push;
  logic [KEY_W-1:0]  push_key;
  logic              push_del;
  logic              out_free;

  walk_t             wk [LEVELS+1];
  sweep_t            sweep;

  assign cfg_n = (cfg_wr_data > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cfg_wr_data;

  assign s_axis_tready = (state == ST_IDLE) && !pend_valid;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign rank_raw      = s_axis_tdata[RANK_W-1:0];
  assign adj = {rank_raw[RANK_W-1], rank_raw}
             + (rank_raw[RANK_W-1] ? {1'b0, live_count} : '0);
  assign in_range = !adj[RANK_W] && (adj[RANK_W-1:0] < live_count);

  assign wk[0].go   = acc && in_range;
  assign wk[0].idx  = '0;
  assign wk[0].rank = adj[LEVELS-1:0];

  assign sweep.en     = (state == ST_SWEEP);
  assign sweep.addr   = sweep_cnt;
  assign sweep.fill_n = fill_n;

  for (genvar g = 1; g <= LEVELS; g++) begin : g_level
    rsds_cell #(.LEVEL(g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .sweep  (sweep),
      .wk_in  (wk[g-1]),
      .wk_out (wk[g])
    );
  end

  assign walk_end = wk[LEVELS].go;
  assign push     = walk_end || (acc && !in_range);
  assign push_key = walk_end ? wk[LEVELS].idx : '0;
  assign push_del = walk_end;
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_cnt  <= '0;
      fill_n     <= '0;
      live_count <= '0;
    end else if (cfg_wr_en) begin
      state      <= ST_SWEEP;
      sweep_cnt  <= '0;
      fill_n     <= cfg_n;
      live_count <= cfg_n;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (&sweep_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc && in_range) begin
            live_count <= live_count - 1'b1;
            state      <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register plus one waiting slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (push) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        pend_valid <= 1'b1;
      end
    end else if (pend_valid && out_free) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_valid && m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_free) begin
        out_key <= push_key;
        out_del <= push_del;
        out_rem <= live_count;
      end else begin
        pend_key <= push_key;
        pend_del <= push_del;
        pend_rem <= live_count;
      end
    end else if (pend_valid && out_free) begin
      out_key <= pend_key;
      out_del <= pend_del;
      out_rem <= pend_rem;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_rem, out_key};
  assign m_axis_tuser  = out_del;

  `RSDS_ASSERT(a_pend_behind_out, pend_valid |-> out_valid, "waiting result without output")
  `RSDS_ASSERT(a_walk_end_state, walk_end |-> (state == ST_WALK), "descent ended outside walk")
  `RSDS_ASSERT(a_live_bound, live_count <= CNT_W'(CAPACITY), "live count above capacity")
  `RSDS_ASSERT_NEXT(a_live_dec, acc && in_range && !cfg_wr_en,
    live_count == ($past(live_count) - 1'b1), "live count not decremented")

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
  import rsds_pkg::*;

  localparam int LIMIT = 400000;
  localparam int PHASE_ITEMS = 50;
  localparam int PHASES = 12;
  localparam int PLAN_ROWS = 28;

  typedef struct packed {
    logic [9:0]  key;
    logic        hit;
    logic [10:0] remain;
  } del_result_t;

  typedef struct packed {
    logic        load;
    logic [10:0] size;
    logic [10:0] rank;
    logic        typed;
    logic [9:0]  key;
    logic        hit;
    logic [10:0] remain;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  bit          key_present [CAPACITY];
  int          live_keys = 0;
  del_result_t pending_results [$];
  del_result_t want;
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // load/size rows reload the set; typed rows carry the result read off directly
  plan_row_t plan [PLAN_ROWS] = '{
    '{1'b0, 11'd0,    11'd0,    1'b1, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'h7ff,  1'b1, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'h3ff,  1'b1, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'h400,  1'b1, 10'd0,    1'b0, 11'd0},
    '{1'b1, 11'd1,    11'd0,    1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'd1,    1'b1, 10'd0,    1'b0, 11'd1},
    '{1'b0, 11'd0,    11'h7fe,  1'b1, 10'd0,    1'b0, 11'd1},
    '{1'b0, 11'd0,    11'h7ff,  1'b1, 10'd0,    1'b1, 11'd0},
    '{1'b1, 11'd1024, 11'd0,    1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'd0,    1'b1, 10'd0,    1'b1, 11'd1023},
    '{1'b0, 11'd0,    11'h7ff,  1'b1, 10'd1023, 1'b1, 11'd1022},
    '{1'b0, 11'd0,    11'h3ff,  1'b1, 10'd0,    1'b0, 11'd1022},
    '{1'b0, 11'd0,    11'h400,  1'b1, 10'd0,    1'b0, 11'd1022},
    '{1'b0, 11'd0,    11'h402,  1'b1, 10'd1,    1'b1, 11'd1021},
    '{1'b0, 11'd0,    11'd500,  1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'd1748, 1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b1, 11'd2047, 11'd0,    1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'h3ff,  1'b1, 10'd1023, 1'b1, 11'd1023},
    '{1'b0, 11'd0,    11'h400,  1'b1, 10'd0,    1'b0, 11'd1023},
    '{1'b0, 11'd0,    11'h401,  1'b1, 10'd0,    1'b1, 11'd1022},
    '{1'b1, 11'd1025, 11'd0,    1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'd512,  1'b1, 10'd512,  1'b1, 11'd1023},
    '{1'b0, 11'd0,    11'd512,  1'b1, 10'd513,  1'b1, 11'd1022},
    '{1'b1, 11'd3,    11'd0,    1'b0, 10'd0,    1'b0, 11'd0},
    '{1'b0, 11'd0,    11'd1,    1'b1, 10'd1,    1'b1, 11'd2},
    '{1'b0, 11'd0,    11'd1,    1'b1, 10'd2,    1'b1, 11'd1},
    '{1'b0, 11'd0,    11'd0,    1'b1, 10'd0,    1'b1, 11'd0},
    '{1'b0, 11'd0,    11'd0,    1'b1, 10'd0,    1'b0, 11'd0}
  };

  rank_select_delete_set_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // req_rank[10:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // deleted_key[9:0], remaining[20:10]
    .m_axis_tuser  (m_axis_tuser)    // deleted
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic load_keys(input logic [10:0] n);
    int lim;
    lim = (int'(n) > CAPACITY) ? CAPACITY : int'(n);
    for (int i = 0; i < CAPACITY; i++) key_present[i] = (i < lim);
    live_keys = lim;
  endtask

  function automatic del_result_t delete_by_rank(input logic [10:0] raw);
    del_result_t r;
    int rank;
    int seen;
    r = '0;
    seen = 0;
    rank = int'($signed(raw));
    if (rank < 0) rank += live_keys;
    if (rank >= 0 && rank < live_keys) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (key_present[i]) begin
          if (seen == rank) begin
            key_present[i] = 1'b0;
            r.key = 10'(i);
            r.hit = 1'b1;
          end
          seen++;
        end
      end
      live_keys--;
    end
    r.remain = 11'(live_keys);
    return r;
  endfunction

  function automatic logic [10:0] pick_rank();
    int v;
    v = $urandom_range(0, 2047);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: if (live_keys > 0) v = $urandom_range(0, live_keys - 1);
      4, 5, 6: if (live_keys > 0) v = -int'($urandom_range(1, live_keys));
      7: if (live_keys < 1024) v = $urandom_range(live_keys, 1023);
      8: if (live_keys < 1024) v = -int'($urandom_range(live_keys + 1, 1024));
      default: ;
    endcase
    return v[10:0];
  endfunction

  // results
  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item tdata=%h tuser=%b",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[9:0] !== want.key)
          report_mismatch($sformatf("deleted_key %0d, want %0d", m_axis_tdata[9:0], want.key));
        if (m_axis_tuser !== want.hit)
          report_mismatch($sformatf("deleted %b, want %b", m_axis_tuser, want.hit));
        if (m_axis_tdata[20:10] !== want.remain)
          report_mismatch($sformatf("remaining %0d, want %0d", m_axis_tdata[20:10],
                                    want.remain));
      end
    end
  end

  task automatic send_rank(input logic [10:0] raw, input logic typed, input del_result_t given);
    del_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, raw};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = delete_by_rank(raw);
    pending_results.push_back(typed ? given : r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_set_size(input logic [10:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    load_keys(v);
  endtask

  initial begin
    logic [10:0] sizes [PHASES];
    sizes = '{11'd1024, 11'd64, 11'd2047, 11'd0, 11'd1, 11'($urandom_range(0, 2047)),
              11'd300, 11'd1025, 11'd17, 11'($urandom_range(0, 1024)), 11'd1024, 11'd2};
    load_keys(11'd0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].load) begin
        wait_idle();
        write_set_size(plan[i].size);
      end else begin
        send_rank(plan[i].rank, plan[i].typed,
                  del_result_t'{plan[i].key, plan[i].hit, plan[i].remain});
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      write_set_size(sizes[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_rank(pick_rank(), 1'b0, '0);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
